/* rtl/rpn_pkg.sv */
// Shared constants, codes and types of the RPN stack calculator.
`timescale 1ns / 1ps

package rpn_pkg;

   localparam int STACK_DEPTH  = 128;
   localparam int ADDR_W       = $clog2(STACK_DEPTH);
   localparam int SP_W         = $clog2(STACK_DEPTH + 1);
   localparam int DATA_W       = 32;
   localparam int DEPTH_W      = 8;
   localparam int DIV_NUM_W    = 48;
   localparam int DIV_DEN_W    = 32;
   localparam int DIV_CNT_W    = $clog2(DIV_NUM_W);
   localparam int TAYLOR_TERMS = 12;

   localparam logic [15:0] LN2_Q16   = 16'd45426;
   // floor(2^47 / LN2_Q16), estimate of |x| / ln2 low by at most one
   localparam logic [31:0] LN2_RECIP = 32'd3098170394;
   localparam logic [31:0] VALUE_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] VALUE_MIN = 32'h8000_0000;

   typedef enum logic [2:0] {
      OP_PUSH, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_VIEW, OP_EXP
   } op_type;

   typedef enum logic [2:0] {
      ST_OK, ST_FULL, ST_EMPTY, ST_ZERO_DIV, ST_SAT, ST_MOD_NEG
   } status_type;

   typedef enum logic [4:0] {
      CMD_NONE, CMD_LOAD, CMD_POP, CMD_CAP_B, CMD_CAP_A, CMD_ZERO_DIV, CMD_MOD_NEG,
      CMD_MUL, CMD_ALU, CMD_DIV_START, CMD_EXP_KR, CMD_EXP_MUL, CMD_EXP_DIVI_START,
      CMD_EXP_ACC, CMD_EXP_FIN, CMD_WRITE, CMD_TOP_RD, CMD_TOP_CAP, CMD_VIEW_RD1,
      CMD_VIEW_RD2, CMD_VIEW_CAP, CMD_OUT, CMD_EXP_RECIP, CMD_EXP_QR
   } dp_cmd_type;

   typedef enum logic [4:0] {
      S_IDLE, S_WRITE, S_POP_B, S_CAP_B, S_POP_A, S_CAP_A, S_DIV_CHECK, S_MOD_CHECK,
      S_MUL, S_ALU, S_DIV_START, S_DIV_WAIT, S_EXP_KR, S_EXP_MUL, S_EXP_ISTART,
      S_EXP_IWAIT, S_EXP_ACC, S_EXP_FIN, S_TOP_RD, S_TOP_CAP, S_VIEW_RD1, S_VIEW_RD2,
      S_VIEW_CAP, S_OUT, S_EXP_RECIP, S_EXP_QR
   } state_type;

   typedef struct packed {
      dp_cmd_type cmd;
      op_type     op;
   } dp_ctrl_type;

   typedef struct packed {
      logic b_zero;
      logic mod_neg;
      logic ib_zero;
      logic exp_early;
      logic i_last;
   } dp_stat_type;

endpackage

/* rtl/rpn_stack_calculator.sv */
// Top level of the RPN stack calculator: sequencer, datapath and shared divider.
`timescale 1ns / 1ps

// Reverse Polish calculator on a 128-entry stack of signed Q16.16 values. One token
// is taken at a time; the result of a token is held in an output register while the
// next token is accepted. Div and mod use the shared 48-step radix-2 divider, and
// exp runs that divider once for each of the twelve series terms; the range
// reduction by ln 2 is a reciprocal multiply and a one-step correction. No clearing
// pass follows reset; only values from written stack entries are ever used.
module rpn_stack_calculator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // number
   input  logic [2:0]  req_tuser,  // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,  // value, second_value, depth
   output logic [2:0]  rsp_tuser   // status
);

   rpn_pkg::dp_ctrl_type          dp_ctrl;
   rpn_pkg::dp_stat_type          dp_stat;
   logic                          div_start, div_busy;
   logic [rpn_pkg::DIV_NUM_W-1:0] div_dividend, div_quot;
   logic [rpn_pkg::DIV_DEN_W-1:0] div_divisor, div_rem;
   logic [31:0]                   rsp_value, rsp_second;
   logic [rpn_pkg::DEPTH_W-1:0]   rsp_depth;

   rpn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_op    (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .div_busy  (div_busy),
      .dp_stat   (dp_stat),
      .dp_ctrl   (dp_ctrl)
   );

   rpn_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .dp_ctrl     (dp_ctrl),
      .req_number  (req_tdata),
      .dp_stat     (dp_stat),
      .div_start   (div_start),
      .div_dividend(div_dividend),
      .div_divisor (div_divisor),
      .div_quot    (div_quot),
      .div_rem     (div_rem),
      .rsp_value   (rsp_value),
      .rsp_second  (rsp_second),
      .rsp_depth   (rsp_depth),
      .rsp_status  (rsp_tuser)
   );

   rpn_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_quot),
      .remainder(div_rem)
   );

   assign rsp_tdata = {rsp_depth, rsp_second, rsp_value};

   a_one_token: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("token accepted while another is in progress");

   a_out_valid: assert property (@(posedge clock) disable iff (reset)
      (dp_ctrl.cmd == rpn_pkg::CMD_OUT) |=> rsp_tvalid)
      else $error("result loaded without valid");

   a_div_busy: assert property (@(posedge clock) disable iff (reset)
      div_start |=> div_busy)
      else $error("divider did not start");

endmodule

/* rtl/rpn_ram.sv */
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module rpn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/rpn_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module rpn_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rpn_pkg::DIV_NUM_W-1:0] dividend,
   input  logic [rpn_pkg::DIV_DEN_W-1:0] divisor,
   output logic                          busy,
   output logic [rpn_pkg::DIV_NUM_W-1:0] quotient,
   output logic [rpn_pkg::DIV_DEN_W-1:0] remainder
);

   logic                          busy_ff, busy_in;
   logic [rpn_pkg::DIV_CNT_W-1:0] count_ff, count_in;
   logic [rpn_pkg::DIV_NUM_W-1:0] quot_ff, quot_in;
   logic [rpn_pkg::DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [rpn_pkg::DIV_DEN_W-1:0] den_ff, den_in;
   logic [rpn_pkg::DIV_DEN_W:0]   shifted;
   logic [rpn_pkg::DIV_DEN_W:0]   diff;
   logic                          ge;

   always_comb begin
      shifted  = {rem_ff, quot_ff[rpn_pkg::DIV_NUM_W-1]};
      ge       = shifted >= {1'b0, den_ff};
      diff     = shifted - {1'b0, den_ff};
      busy_in  = busy_ff;
      count_in = count_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = rpn_pkg::DIV_CNT_W'(rpn_pkg::DIV_NUM_W - 1);
         quot_in  = dividend;
         rem_in   = '0;
         den_in   = divisor;
      end else if (busy_ff) begin
         quot_in  = {quot_ff[rpn_pkg::DIV_NUM_W-2:0], ge};
         rem_in   = ge ? diff[rpn_pkg::DIV_DEN_W-1:0] : shifted[rpn_pkg::DIV_DEN_W-1:0];
         count_in = count_ff - 1'b1;
         if (count_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      count_ff <= count_in;
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;

endmodule

/* rtl/rpn_ctrl.sv */
// Token sequencer: walks each token through the pops, arithmetic, push and report that its op needs.
`timescale 1ns / 1ps

module rpn_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [2:0]           req_op,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic                 div_busy,
   input  rpn_pkg::dp_stat_type dp_stat,
   output rpn_pkg::dp_ctrl_type dp_ctrl
);

   rpn_pkg::state_type state_ff, state_in;
   rpn_pkg::op_type    op_ff, op_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rpn_pkg::dp_cmd_type cmd;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      cmd          = rpn_pkg::CMD_NONE;
      req_tready   = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      case (state_ff)
         rpn_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op_in = rpn_pkg::op_type'(req_op);
               cmd   = rpn_pkg::CMD_LOAD;
               case (rpn_pkg::op_type'(req_op))
                  rpn_pkg::OP_PUSH: state_in = rpn_pkg::S_WRITE;
                  rpn_pkg::OP_VIEW: state_in = rpn_pkg::S_VIEW_RD1;
                  default:          state_in = rpn_pkg::S_POP_B;
               endcase
            end
         end
         rpn_pkg::S_POP_B: begin
            cmd      = rpn_pkg::CMD_POP;
            state_in = rpn_pkg::S_CAP_B;
         end
         rpn_pkg::S_CAP_B: begin
            cmd = rpn_pkg::CMD_CAP_B;
            case (op_ff)
               rpn_pkg::OP_DIV: state_in = rpn_pkg::S_DIV_CHECK;
               rpn_pkg::OP_EXP: state_in = rpn_pkg::S_EXP_RECIP;
               default:         state_in = rpn_pkg::S_POP_A;
            endcase
         end
         rpn_pkg::S_DIV_CHECK: begin
            if (dp_stat.b_zero) begin
               cmd      = rpn_pkg::CMD_ZERO_DIV;
               state_in = rpn_pkg::S_TOP_RD;
            end else begin
               cmd      = rpn_pkg::CMD_POP;
               state_in = rpn_pkg::S_CAP_A;
            end
         end
         rpn_pkg::S_POP_A: begin
            cmd      = rpn_pkg::CMD_POP;
            state_in = rpn_pkg::S_CAP_A;
         end
         rpn_pkg::S_CAP_A: begin
            cmd = rpn_pkg::CMD_CAP_A;
            case (op_ff)
               rpn_pkg::OP_MUL: state_in = rpn_pkg::S_MUL;
               rpn_pkg::OP_DIV: state_in = rpn_pkg::S_DIV_START;
               rpn_pkg::OP_MOD: state_in = rpn_pkg::S_MOD_CHECK;
               default:         state_in = rpn_pkg::S_ALU;
            endcase
         end
         rpn_pkg::S_MOD_CHECK: begin
            if (dp_stat.mod_neg) begin
               cmd      = rpn_pkg::CMD_MOD_NEG;
               state_in = rpn_pkg::S_TOP_RD;
            end else if (dp_stat.ib_zero) begin
               cmd      = rpn_pkg::CMD_ZERO_DIV;
               state_in = rpn_pkg::S_TOP_RD;
            end else begin
               cmd      = rpn_pkg::CMD_DIV_START;
               state_in = rpn_pkg::S_DIV_WAIT;
            end
         end
         rpn_pkg::S_MUL: begin
            cmd      = rpn_pkg::CMD_MUL;
            state_in = rpn_pkg::S_ALU;
         end
         rpn_pkg::S_DIV_START: begin
            cmd      = rpn_pkg::CMD_DIV_START;
            state_in = rpn_pkg::S_DIV_WAIT;
         end
         rpn_pkg::S_DIV_WAIT: begin
            if (!div_busy) begin
               state_in = rpn_pkg::S_ALU;
            end
         end
         rpn_pkg::S_ALU: begin
            cmd      = rpn_pkg::CMD_ALU;
            state_in = rpn_pkg::S_WRITE;
         end
         rpn_pkg::S_WRITE: begin
            cmd      = rpn_pkg::CMD_WRITE;
            state_in = rpn_pkg::S_TOP_RD;
         end
         rpn_pkg::S_TOP_RD: begin
            cmd      = rpn_pkg::CMD_TOP_RD;
            state_in = rpn_pkg::S_TOP_CAP;
         end
         rpn_pkg::S_TOP_CAP: begin
            cmd      = rpn_pkg::CMD_TOP_CAP;
            state_in = rpn_pkg::S_OUT;
         end
         rpn_pkg::S_EXP_RECIP: begin
            cmd      = rpn_pkg::CMD_EXP_RECIP;
            state_in = rpn_pkg::S_EXP_QR;
         end
         rpn_pkg::S_EXP_QR: begin
            cmd      = rpn_pkg::CMD_EXP_QR;
            state_in = rpn_pkg::S_EXP_KR;
         end
         rpn_pkg::S_EXP_KR: begin
            cmd      = rpn_pkg::CMD_EXP_KR;
            state_in = dp_stat.exp_early ? rpn_pkg::S_OUT : rpn_pkg::S_EXP_MUL;
         end
         rpn_pkg::S_EXP_MUL: begin
            cmd      = rpn_pkg::CMD_EXP_MUL;
            state_in = rpn_pkg::S_EXP_ISTART;
         end
         rpn_pkg::S_EXP_ISTART: begin
            cmd      = rpn_pkg::CMD_EXP_DIVI_START;
            state_in = rpn_pkg::S_EXP_IWAIT;
         end
         rpn_pkg::S_EXP_IWAIT: begin
            if (!div_busy) begin
               state_in = rpn_pkg::S_EXP_ACC;
            end
         end
         rpn_pkg::S_EXP_ACC: begin
            cmd      = rpn_pkg::CMD_EXP_ACC;
            state_in = dp_stat.i_last ? rpn_pkg::S_EXP_FIN : rpn_pkg::S_EXP_MUL;
         end
         rpn_pkg::S_EXP_FIN: begin
            cmd      = rpn_pkg::CMD_EXP_FIN;
            state_in = rpn_pkg::S_OUT;
         end
         rpn_pkg::S_VIEW_RD1: begin
            cmd      = rpn_pkg::CMD_VIEW_RD1;
            state_in = rpn_pkg::S_VIEW_RD2;
         end
         rpn_pkg::S_VIEW_RD2: begin
            cmd      = rpn_pkg::CMD_VIEW_RD2;
            state_in = rpn_pkg::S_VIEW_CAP;
         end
         rpn_pkg::S_VIEW_CAP: begin
            cmd      = rpn_pkg::CMD_VIEW_CAP;
            state_in = rpn_pkg::S_OUT;
         end
         rpn_pkg::S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd          = rpn_pkg::CMD_OUT;
               rsp_valid_in = 1'b1;
               state_in     = rpn_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = rpn_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rpn_pkg::S_IDLE;
         op_ff        <= rpn_pkg::OP_PUSH;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign dp_ctrl.cmd = cmd;
   assign dp_ctrl.op  = op_ff;

endmodule

/* rtl/rpn_dp.sv */
// Datapath: value stack, operand and result registers, ALU and exp series.
`timescale 1ns / 1ps

module rpn_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  rpn_pkg::dp_ctrl_type          dp_ctrl,
   input  logic [31:0]                   req_number,
   output rpn_pkg::dp_stat_type          dp_stat,
   output logic                          div_start,
   output logic [rpn_pkg::DIV_NUM_W-1:0] div_dividend,
   output logic [rpn_pkg::DIV_DEN_W-1:0] div_divisor,
   input  logic [rpn_pkg::DIV_NUM_W-1:0] div_quot,
   input  logic [rpn_pkg::DIV_DEN_W-1:0] div_rem,
   output logic [31:0]                   rsp_value,
   output logic [31:0]                   rsp_second,
   output logic [rpn_pkg::DEPTH_W-1:0]   rsp_depth,
   output logic [2:0]                    rsp_status
);

   logic [rpn_pkg::SP_W-1:0]    sp_ff, sp_m1, sp_m2;
   logic signed [31:0]          a_ff, b_ff, cap_val;
   logic [31:0]                 w_data_ff;
   logic                        pop_empty_ff, empty_ff, sat_ff;
   rpn_pkg::status_type         code_ff, final_status;
   logic signed [63:0]          prod_ff, mul_adj, alu_wide, dq;
   logic [31:0]                 alu_res;
   logic                        alu_sat;
   logic [30:0]                 term_ff;
   logic [31:0]                 sum_ff, exp_res;
   logic [29:0]                 r30_ff;
   logic [5:0]                  sh_ff;
   logic [3:0]                  i_ff;
   logic [31:0]                 value_ff, second_ff;
   logic [rpn_pkg::DEPTH_W-1:0] depth_ff;
   logic [31:0]                 out_value_ff, out_second_ff;
   logic [rpn_pkg::DEPTH_W-1:0] out_depth_ff;
   rpn_pkg::status_type         out_status_ff;
   logic [31:0]                 a_abs, b_abs;
   logic                        div_neg;
   logic [17:0]                 k_pos;
   logic signed [17:0]          k_val, sh_full;
   logic [15:0]                 erem, r_val;
   logic                        erem_nz, exp_big, exp_small;
   logic [60:0]                 exp_prod;
   logic [63:0]                 recip_prod;
   logic [16:0]                 q_est, q_fix, kq_ff;
   logic [32:0]                 qe_mul;
   logic [31:0]                 rem_est;
   logic                        rem_ge;
   logic [15:0]                 rem_fix, erem_ff;
   logic                        rd_en, wr_en;
   logic [rpn_pkg::ADDR_W-1:0]  rd_addr;
   logic [31:0]                 rd_data;

   rpn_ram #(
      .WIDTH(rpn_pkg::DATA_W),
      .DEPTH(rpn_pkg::STACK_DEPTH)
   ) u_stack (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(sp_ff[rpn_pkg::ADDR_W-1:0]),
      .wr_data(w_data_ff),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      sp_m1   = sp_ff - 1'b1;
      sp_m2   = sp_ff - 2'd2;
      rd_addr = sp_m1[rpn_pkg::ADDR_W-1:0];
      rd_en   = 1'b0;
      case (dp_ctrl.cmd)
         rpn_pkg::CMD_POP, rpn_pkg::CMD_TOP_RD, rpn_pkg::CMD_VIEW_RD1: rd_en = 1'b1;
         rpn_pkg::CMD_VIEW_RD2: begin
            rd_en   = 1'b1;
            rd_addr = sp_m2[rpn_pkg::ADDR_W-1:0];
         end
         default: rd_en = 1'b0;
      endcase
      wr_en = (dp_ctrl.cmd == rpn_pkg::CMD_WRITE) &&
              (sp_ff < rpn_pkg::SP_W'(rpn_pkg::STACK_DEPTH));
      cap_val = pop_empty_ff ? 32'sd0 : $signed(rd_data);
   end

   always_comb begin
      a_abs   = a_ff[31] ? (~a_ff + 32'd1) : a_ff;
      b_abs   = b_ff[31] ? (~b_ff + 32'd1) : b_ff;
      div_neg = a_ff[31] ^ b_ff[31];
      mul_adj = prod_ff + (prod_ff[63] ? 64'sd65535 : 64'sd0);
      dq      = $signed({16'b0, div_quot});
      case (dp_ctrl.op)
         rpn_pkg::OP_ADD: alu_wide = 64'(a_ff) + 64'(b_ff);
         rpn_pkg::OP_SUB: alu_wide = 64'(a_ff) - 64'(b_ff);
         rpn_pkg::OP_MUL: alu_wide = mul_adj >>> 16;
         rpn_pkg::OP_DIV: alu_wide = div_neg ? -dq : dq;
         rpn_pkg::OP_MOD: alu_wide = $signed({32'b0, div_rem[15:0], 16'b0});
         default:         alu_wide = 64'sd0;
      endcase
      alu_sat = 1'b1;
      if (alu_wide > 64'sd2147483647) begin
         alu_res = rpn_pkg::VALUE_MAX;
      end else if (alu_wide < -64'sd2147483648) begin
         alu_res = rpn_pkg::VALUE_MIN;
      end else begin
         alu_res = alu_wide[31:0];
         alu_sat = 1'b0;
      end
   end

   always_comb begin
      div_start    = (dp_ctrl.cmd == rpn_pkg::CMD_DIV_START) ||
                     (dp_ctrl.cmd == rpn_pkg::CMD_EXP_DIVI_START);
      div_dividend = {17'b0, prod_ff[60:30]};
      div_divisor  = {28'b0, i_ff};
      if (dp_ctrl.cmd == rpn_pkg::CMD_DIV_START) begin
         case (dp_ctrl.op)
            rpn_pkg::OP_MOD: begin
               div_dividend = {32'b0, a_ff[31:16]};
               div_divisor  = {16'b0, b_ff[31:16]};
            end
            default: begin
               div_dividend = {a_abs, 16'b0};
               div_divisor  = b_abs;
            end
         endcase
      end
   end

   always_comb begin
      recip_prod = b_abs * rpn_pkg::LN2_RECIP;
      q_est      = prod_ff[63:47];
      qe_mul     = q_est * rpn_pkg::LN2_Q16;
      rem_est    = b_abs - qe_mul[31:0];
      rem_ge     = rem_est >= {16'b0, rpn_pkg::LN2_Q16};
      q_fix      = q_est + {16'b0, rem_ge};
      rem_fix    = rem_ge ? (rem_est[15:0] - rpn_pkg::LN2_Q16) : rem_est[15:0];
      erem      = erem_ff;
      erem_nz   = erem != 16'd0;
      k_pos     = {1'b0, kq_ff};
      k_val     = b_ff[31] ? $signed(18'd0 - k_pos - {17'b0, erem_nz}) : $signed(k_pos);
      r_val     = (b_ff[31] && erem_nz) ? (rpn_pkg::LN2_Q16 - erem) : erem;
      exp_big   = k_val > 18'sd14;
      exp_small = k_val < -18'sd40;
      sh_full   = 18'sd14 - k_val;
      exp_prod  = term_ff * r30_ff;
      exp_res   = (sh_ff >= 6'd32) ? 32'd0 : (sum_ff >> sh_ff[4:0]);
   end

   assign dp_stat.b_zero    = b_ff == 32'sd0;
   assign dp_stat.mod_neg   = a_ff[31] | b_ff[31];
   assign dp_stat.ib_zero   = b_ff[31:16] == 16'd0;
   assign dp_stat.exp_early = exp_big | exp_small;
   assign dp_stat.i_last    = i_ff == 4'(rpn_pkg::TAYLOR_TERMS);

   always_comb begin
      if (empty_ff) begin
         final_status = rpn_pkg::ST_EMPTY;
      end else if (code_ff != rpn_pkg::ST_OK) begin
         final_status = code_ff;
      end else if (sat_ff) begin
         final_status = rpn_pkg::ST_SAT;
      end else begin
         final_status = rpn_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff        <= '0;
         pop_empty_ff <= 1'b0;
         empty_ff     <= 1'b0;
         sat_ff       <= 1'b0;
         code_ff      <= rpn_pkg::ST_OK;
      end else begin
         case (dp_ctrl.cmd)
            rpn_pkg::CMD_LOAD: begin
               empty_ff <= 1'b0;
               sat_ff   <= 1'b0;
               code_ff  <= rpn_pkg::ST_OK;
            end
            rpn_pkg::CMD_POP: begin
               if (sp_ff != '0) begin
                  sp_ff        <= sp_m1;
                  pop_empty_ff <= 1'b0;
               end else begin
                  pop_empty_ff <= 1'b1;
                  empty_ff     <= 1'b1;
               end
            end
            rpn_pkg::CMD_ZERO_DIV: code_ff <= rpn_pkg::ST_ZERO_DIV;
            rpn_pkg::CMD_MOD_NEG:  code_ff <= rpn_pkg::ST_MOD_NEG;
            rpn_pkg::CMD_ALU: begin
               if (alu_sat) begin
                  sat_ff <= 1'b1;
               end
            end
            rpn_pkg::CMD_WRITE: begin
               if (wr_en) begin
                  sp_ff <= sp_ff + 1'b1;
               end else begin
                  code_ff <= rpn_pkg::ST_FULL;
               end
            end
            rpn_pkg::CMD_EXP_KR: begin
               if (exp_big) begin
                  sat_ff <= 1'b1;
               end
            end
            rpn_pkg::CMD_EXP_FIN: begin
               if (exp_res[31]) begin
                  sat_ff <= 1'b1;
               end
            end
            rpn_pkg::CMD_VIEW_CAP: begin
               if (sp_ff == '0) begin
                  empty_ff <= 1'b1;
               end
               sp_ff <= '0;
            end
            default: begin
               sp_ff <= sp_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (dp_ctrl.cmd)
         rpn_pkg::CMD_LOAD:  w_data_ff <= req_number;
         rpn_pkg::CMD_CAP_B: b_ff      <= cap_val;
         rpn_pkg::CMD_CAP_A: a_ff      <= cap_val;
         rpn_pkg::CMD_MUL:   prod_ff   <= a_ff * b_ff;
         rpn_pkg::CMD_ALU:   w_data_ff <= alu_res;
         rpn_pkg::CMD_EXP_RECIP: prod_ff <= $signed(recip_prod);
         rpn_pkg::CMD_EXP_QR: begin
            kq_ff   <= q_fix;
            erem_ff <= rem_fix;
         end
         rpn_pkg::CMD_TOP_CAP: begin
            value_ff  <= (sp_ff != '0) ? rd_data : 32'd0;
            second_ff <= 32'd0;
            depth_ff  <= rpn_pkg::DEPTH_W'(sp_ff);
         end
         rpn_pkg::CMD_EXP_KR: begin
            depth_ff  <= rpn_pkg::DEPTH_W'(sp_ff);
            second_ff <= 32'd0;
            sh_ff     <= sh_full[5:0];
            r30_ff    <= {r_val, 14'b0};
            term_ff   <= 31'h4000_0000;
            sum_ff    <= 32'h4000_0000;
            i_ff      <= 4'd1;
            if (exp_big) begin
               value_ff <= rpn_pkg::VALUE_MAX;
            end else begin
               value_ff <= 32'd0;
            end
         end
         rpn_pkg::CMD_EXP_MUL: prod_ff <= $signed({3'b0, exp_prod});
         rpn_pkg::CMD_EXP_ACC: begin
            term_ff <= div_quot[30:0];
            sum_ff  <= sum_ff + div_quot[31:0];
            i_ff    <= i_ff + 4'd1;
         end
         rpn_pkg::CMD_EXP_FIN: value_ff <= exp_res[31] ? rpn_pkg::VALUE_MAX : exp_res;
         rpn_pkg::CMD_VIEW_RD2: value_ff <= (sp_ff != '0) ? rd_data : 32'd0;
         rpn_pkg::CMD_VIEW_CAP: begin
            second_ff <= (sp_ff >= rpn_pkg::SP_W'(2)) ? rd_data : 32'd0;
            depth_ff  <= rpn_pkg::DEPTH_W'(sp_ff);
         end
         rpn_pkg::CMD_OUT: begin
            out_value_ff  <= value_ff;
            out_second_ff <= second_ff;
            out_depth_ff  <= depth_ff;
            out_status_ff <= final_status;
         end
         default: begin
            w_data_ff <= w_data_ff;
         end
      endcase
   end

   assign rsp_value  = out_value_ff;
   assign rsp_second = out_second_ff;
   assign rsp_depth  = out_depth_ff;
   assign rsp_status = out_status_ff;

endmodule

/* dv/rpn_stack_calculator_test.sv */
// Self-checking testbench of the RPN stack calculator: directed tokens, then random token streams.
`timescale 1ns / 1ps

class rpn_calc_scoreboard;
   logic signed [31:0] stack_mem[128];
   int unsigned        sp;
   logic [74:0]        pending[$];
   int                 mismatches;

   function new();
      sp = 0;
      mismatches = 0;
   endfunction

   function logic signed [31:0] clamp(logic signed [63:0] v, ref bit sat);
      if (v > 64'sh7FFF_FFFF) begin
         sat = 1;
         return 32'sh7FFF_FFFF;
      end
      if (v < -64'sh8000_0000) begin
         sat = 1;
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   function logic signed [31:0] pop(ref bit empty);
      if (sp > 0) begin
         sp--;
         return stack_mem[sp];
      end
      empty = 1;
      return 0;
   endfunction

   function void push(logic signed [31:0] v);
      if (sp < 128) begin
         stack_mem[sp] = v;
         sp++;
      end
   endfunction

   function logic signed [31:0] exp_q16(logic signed [31:0] x, ref bit sat);
      longint k, r;
      longint unsigned r30, term, sum, res;
      k = longint'(x) / 45426;
      r = longint'(x) - k * 45426;
      if (r < 0) begin
         k--;
         r += 45426;
      end
      if (k > 14) begin
         sat = 1;
         return 32'sh7FFF_FFFF;
      end
      if (k < -40) return 0;
      r30 = longint'(r) << 14;
      term = 64'd1 << 30;
      sum = term;
      for (int i = 1; i <= 12; i++) begin
         term = ((term * r30) >> 30) / i;
         sum += term;
      end
      res = sum >> (14 - k);
      if (res > 64'h7FFF_FFFF) begin
         sat = 1;
         return 32'sh7FFF_FFFF;
      end
      return res[31:0];
   endfunction

   function void note_token(rpn_pkg::op_type op, logic signed [31:0] num);
      bit empty, sat, top;
      rpn_pkg::status_type st;
      logic signed [31:0] a, b, value, second;
      longint ia, ib;
      int unsigned depth;
      empty = 0;
      sat = 0;
      top = 1;
      st = rpn_pkg::ST_OK;
      value = 0;
      second = 0;
      case (op)
         rpn_pkg::OP_PUSH: begin
            if (sp >= 128) st = rpn_pkg::ST_FULL;
            else push(num);
         end
         rpn_pkg::OP_ADD: begin
            b = pop(empty);
            a = pop(empty);
            push(clamp(longint'(a) + b, sat));
         end
         rpn_pkg::OP_SUB: begin
            b = pop(empty);
            a = pop(empty);
            push(clamp(longint'(a) - b, sat));
         end
         rpn_pkg::OP_MUL: begin
            b = pop(empty);
            a = pop(empty);
            push(clamp((longint'(a) * b) / 65536, sat));
         end
         rpn_pkg::OP_DIV: begin
            b = pop(empty);
            if (b == 0) st = rpn_pkg::ST_ZERO_DIV;
            else begin
               a = pop(empty);
               push(clamp((longint'(a) * 65536) / b, sat));
            end
         end
         rpn_pkg::OP_MOD: begin
            b = pop(empty);
            a = pop(empty);
            if (a < 0 || b < 0) st = rpn_pkg::ST_MOD_NEG;
            else begin
               ia = longint'(a) / 65536;
               ib = longint'(b) / 65536;
               if (ib == 0) st = rpn_pkg::ST_ZERO_DIV;
               else push(32'((ia % ib) * 65536));
            end
         end
         rpn_pkg::OP_VIEW: begin
            depth = sp;
            if (depth >= 1) value = stack_mem[depth - 1];
            if (depth >= 2) second = stack_mem[depth - 2];
            sp = 0;
            pending.push_back({depth == 0 ? rpn_pkg::ST_EMPTY : rpn_pkg::ST_OK,
                               8'(depth), second, value});
            return;
         end
         default: begin
            top = 0;
            a = pop(empty);
            value = exp_q16(a, sat);
         end
      endcase
      if (top && sp > 0) value = stack_mem[sp - 1];
      if (sat && st == rpn_pkg::ST_OK) st = rpn_pkg::ST_SAT;
      if (empty) st = rpn_pkg::ST_EMPTY;
      pending.push_back({st, 8'(sp), second, value});
   endfunction

   function void check_result(logic [71:0] data, logic [2:0] user);
      logic [74:0] exp_item;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result %h %h", data, user);
         return;
      end
      exp_item = pending.pop_front();
      if (exp_item[71:0] !== data || exp_item[74:72] !== user) begin
         mismatches++;
         if (mismatches <= 10)
            $display({"mismatch: expected value %h second %h depth %0d status %0d, ",
                      "got value %h second %h depth %0d status %0d"},
                     exp_item[31:0], exp_item[63:32], exp_item[71:64], exp_item[74:72],
                     data[31:0], data[63:32], data[71:64], user);
      end
   endfunction
endclass

module rpn_stack_calculator_test;
   import rpn_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [31:0] req_tdata = 0;
   logic [2:0]  req_tuser = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [71:0] rsp_tdata;
   logic [2:0]  rsp_tuser;

   rpn_calc_scoreboard calc_board = new();
   int unsigned cycle_count = 0;
   bit          stim_done = 0;

   rpn_stack_calculator DUT (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 2_000_000) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) calc_board.check_result(rsp_tdata, rsp_tuser);

   initial begin
      int gap;
      @(posedge clock);
      forever begin
         gap = $urandom_range(0, 10);
         if ($urandom_range(0, 3) == 0) gap = 0;
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   function automatic logic [31:0] rand_number();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 20) << 16;
         1: return -($urandom_range(0, 20) << 16);
         2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         3: return $urandom_range(0, 300000) - 150000;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_token(op_type op, logic [31:0] num);
      int gap;
      gap = $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= op;
      req_tdata  <= num;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      calc_board.note_token(op, num);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (calc_board.pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      op_type op;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_token(OP_ADD, 0);
      send_token(OP_VIEW, 0);
      send_token(OP_EXP, 0);
      send_token(OP_PUSH, 32'h7FFF_FFFF);
      send_token(OP_PUSH, 32'h7FFF_FFFF);
      send_token(OP_ADD, 0);
      send_token(OP_PUSH, 32'h8000_0000);
      send_token(OP_MUL, 0);
      send_token(OP_PUSH, 0);
      send_token(OP_DIV, 0);
      send_token(OP_PUSH, 32'h0003_0000);
      send_token(OP_DIV, 0);
      send_token(OP_PUSH, 32'hFFFF_8000);
      send_token(OP_MOD, 0);
      send_token(OP_PUSH, 32'h0007_0000);
      send_token(OP_PUSH, 32'h0000_8000);
      send_token(OP_MOD, 0);
      send_token(OP_PUSH, 32'h000A_0000);
      send_token(OP_PUSH, 32'h0003_0000);
      send_token(OP_MOD, 0);
      send_token(OP_SUB, 0);
      send_token(OP_PUSH, 32'h000A_0000);
      send_token(OP_EXP, 0);
      send_token(OP_PUSH, 32'hFFE0_0000);
      send_token(OP_EXP, 0);
      send_token(OP_VIEW, 0);
      drain();
      for (int i = 0; i < 130; i++) send_token(OP_PUSH, $urandom);
      send_token(OP_VIEW, 0);
      drain();
      for (int i = 0; i < 420; i++) begin
         if ($urandom_range(0, 9) < 4 || calc_board.sp < 2) op = OP_PUSH;
         else if ($urandom_range(0, 9) == 0) op = op_type'($urandom_range(5, 7));
         else op = op_type'($urandom_range(1, 7));
         send_token(op, (op == OP_PUSH || $urandom_range(0, 3) == 0) ? rand_number() : $urandom);
      end
      drain();
      repeat (800) @(posedge clock);
      if (calc_board.mismatches == 0 && calc_board.pending.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule

/* filelist.f */
rtl/rpn_pkg.sv
rtl/rpn_ram.sv
rtl/rpn_div.sv
rtl/rpn_ctrl.sv
rtl/rpn_dp.sv
rtl/rpn_stack_calculator.sv
dv/rpn_stack_calculator_test.sv
